// ===== rtl/core/bcp_pkg.sv =====
// Shared types and constants of the byte bigram count and predict block.
package bcp_pkg;

   localparam int ALPHA_BITS = 8;
   localparam int COUNT_BITS = 16;
   localparam int TOTAL_BITS = 24;
   localparam int DIST_BITS  = 9;
   localparam int LFSR_BITS  = 16;
   localparam int RUN_BITS   = 6;
   localparam int PAIR_DEPTH = 65536;
   localparam int ROW_DEPTH  = 256;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
   localparam logic [LFSR_BITS-1:0]  LFSR_MASK = 16'hB400;
   localparam logic [LFSR_BITS-1:0]  SEED_RESET = 16'd1;

   typedef enum logic [1:0] {
      CMD_LEARN   = 2'd0,
      CMD_PREDICT = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEARN,
      ST_QUERY,
      ST_SCAN_MAX,
      ST_DIV,
      ST_SCAN_PICK,
      ST_EMIT,
      ST_STOP
   } state_type;

   localparam logic CSR_SEED = 1'b0;

endpackage

// ===== rtl/core/bcp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module bcp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/bigram_count_and_predict.sv =====
// Byte bigram model: learn pairs, predict most frequent successors, query counts.
//
//  channel | direction | contents
//  req     | in        | tuser: command; tdata: byte, successor, new_text, length
//  rsp     | out       | tuser: kind; tdata: byte, count, total, seen, distinct; tlast
//  csr     | in/out    | APB register 0: random_seed
//
// Learn is an accept, then a read-modify-write of the pair, total and seen memories.
// Query reads the memories on accept, then waits for the result register to be free.
// Each predicted byte is a scan of the pair memory row for the maximum, a divider for
// the tie pick, a second scan, then an emit; a row with no successor gives a stop result.
// After reset a pass over all 65536 pair addresses clears the memories; no request is taken meanwhile.
// A stalled rsp holds the result register; the next request is still taken, whatever its
// command, and a query or predict then waits to load its result.
module bigram_count_and_predict (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_value, successor_byte, new_text, predict_length
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_byte, pair_count, successor_total, seen, distinct_count
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bcp_pkg::state_type state_ff, state_in;

   logic [7:0]  ctx_ff, ctx_in;
   logic [5:0]  remain_ff, remain_in;
   logic [8:0]  scan_cnt_ff, scan_cnt_in;
   logic        dv_ff, dv_in;
   logic [7:0]  col_ff, col_in;
   logic [15:0] best_ff, best_in;
   logic [8:0]  ties_ff, ties_in;
   logic [15:0] div_sh_ff, div_sh_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  match_ff, match_in;
   logic [7:0]  pick_ff, pick_in;
   logic        learn_en_ff, learn_en_in;
   logic [15:0] learn_addr_ff, learn_addr_in;
   logic [15:0] clr_cnt_ff, clr_cnt_in;
   logic [8:0]  distinct_ff, distinct_in;
   logic [7:0]  prev_ff, prev_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [15:0] seed_ff, seed_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [15:0] out_count_ff, out_count_in;
   logic [23:0] out_total_ff, out_total_in;
   logic        out_seen_ff, out_seen_in;
   logic [8:0]  out_distinct_ff, out_distinct_in;
   logic        out_last_ff, out_last_in;

   logic        pr_wr_en, pr_rd_en;
   logic [15:0] pr_wr_addr, pr_rd_addr, pr_wr_data, pr_rd_data;
   logic        tr_wr_en, tr_rd_en;
   logic [7:0]  tr_wr_addr, tr_rd_addr;
   logic [23:0] tr_wr_data, tr_rd_data;
   logic        sr_wr_en, sr_rd_en;
   logic [7:0]  sr_wr_addr, sr_rd_addr;
   logic [0:0]  sr_wr_data, sr_rd_data;

   logic        accept, out_free, csr_write, issuing, scan_done, pair_inc;
   logic [1:0]  in_cmd;
   logic [7:0]  in_byte, in_succ;
   logic        in_new_text;
   logic [5:0]  in_len;
   logic [15:0] lfsr_step;
   logic [9:0]  div_trial;

   bcp_ram #(.WIDTH(bcp_pkg::COUNT_BITS), .DEPTH(bcp_pkg::PAIR_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pr_wr_en),
      .wr_addr (pr_wr_addr),
      .wr_data (pr_wr_data),
      .rd_en   (pr_rd_en),
      .rd_addr (pr_rd_addr),
      .rd_data (pr_rd_data)
   );

   bcp_ram #(.WIDTH(bcp_pkg::TOTAL_BITS), .DEPTH(bcp_pkg::ROW_DEPTH)) u_total_ram (
      .clock   (clock),
      .wr_en   (tr_wr_en),
      .wr_addr (tr_wr_addr),
      .wr_data (tr_wr_data),
      .rd_en   (tr_rd_en),
      .rd_addr (tr_rd_addr),
      .rd_data (tr_rd_data)
   );

   bcp_ram #(.WIDTH(1), .DEPTH(bcp_pkg::ROW_DEPTH)) u_seen_ram (
      .clock   (clock),
      .wr_en   (sr_wr_en),
      .wr_addr (sr_wr_addr),
      .wr_data (sr_wr_data),
      .rd_en   (sr_rd_en),
      .rd_addr (sr_rd_addr),
      .rd_data (sr_rd_data)
   );

   assign in_cmd      = req_tuser;
   assign in_byte     = req_tdata[7:0];
   assign in_succ     = req_tdata[15:8];
   assign in_new_text = req_tdata[16];
   assign in_len      = req_tdata[22:17];

   assign req_tready = (state_ff == bcp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bcp_pkg::CSR_SEED) ? {16'd0, seed_ff} : 32'd0;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'd0, out_distinct_ff, out_seen_ff, out_total_ff, out_count_ff,
                        out_byte_ff};

   assign issuing   = !scan_cnt_ff[8];
   assign scan_done = scan_cnt_ff[8] && !dv_ff;
   assign pair_inc  = learn_en_ff && (pr_rd_data != bcp_pkg::COUNT_MAX);
   assign lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? bcp_pkg::LFSR_MASK : 16'd0);
   assign div_trial = {rem_ff, div_sh_ff[15]};

   always_comb begin
      state_in        = state_ff;
      ctx_in          = ctx_ff;
      remain_in       = remain_ff;
      scan_cnt_in     = scan_cnt_ff;
      dv_in           = 1'b0;
      col_in          = col_ff;
      best_in         = best_ff;
      ties_in         = ties_ff;
      div_sh_in       = div_sh_ff;
      div_cnt_in      = div_cnt_ff;
      rem_in          = rem_ff;
      match_in        = match_ff;
      pick_in         = pick_ff;
      learn_en_in     = learn_en_ff;
      learn_addr_in   = learn_addr_ff;
      clr_cnt_in      = clr_cnt_ff;
      distinct_in     = distinct_ff;
      prev_in         = prev_ff;
      prev_valid_in   = prev_valid_ff;
      lfsr_in         = lfsr_ff;
      seed_in         = seed_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      out_kind_in     = out_kind_ff;
      out_byte_in     = out_byte_ff;
      out_count_in    = out_count_ff;
      out_total_in    = out_total_ff;
      out_seen_in     = out_seen_ff;
      out_distinct_in = out_distinct_ff;
      out_last_in     = out_last_ff;

      pr_wr_en   = 1'b0;
      pr_wr_addr = learn_addr_ff;
      pr_wr_data = pr_rd_data + 16'd1;
      pr_rd_en   = 1'b0;
      pr_rd_addr = {ctx_ff, scan_cnt_ff[7:0]};
      tr_wr_en   = 1'b0;
      tr_wr_addr = learn_addr_ff[15:8];
      tr_wr_data = tr_rd_data + 24'd1;
      tr_rd_en   = 1'b0;
      tr_rd_addr = ctx_ff;
      sr_wr_en   = 1'b0;
      sr_wr_addr = learn_addr_ff[7:0];
      sr_wr_data = 1'b1;
      sr_rd_en   = 1'b0;
      sr_rd_addr = ctx_ff;

      if (csr_write && csr_paddr[2] == bcp_pkg::CSR_SEED) begin
         seed_in = csr_pwdata[15:0];
         lfsr_in = (csr_pwdata[15:0] != 16'd0) ? csr_pwdata[15:0] : bcp_pkg::SEED_RESET;
      end

      unique case (state_ff)
         bcp_pkg::ST_CLEAR: begin
            pr_wr_en   = 1'b1;
            pr_wr_addr = clr_cnt_ff;
            pr_wr_data = '0;
            tr_wr_en   = 1'b1;
            tr_wr_addr = clr_cnt_ff[7:0];
            tr_wr_data = '0;
            sr_wr_en   = 1'b1;
            sr_wr_addr = clr_cnt_ff[7:0];
            sr_wr_data = '0;
            clr_cnt_in = clr_cnt_ff + 16'd1;
            if (clr_cnt_ff == 16'hFFFF) begin
               state_in = bcp_pkg::ST_IDLE;
            end
         end
         bcp_pkg::ST_IDLE: begin
            if (accept) begin
               case (in_cmd)
                  bcp_pkg::CMD_LEARN: begin
                     pr_rd_en      = 1'b1;
                     pr_rd_addr    = {prev_ff, in_byte};
                     tr_rd_en      = 1'b1;
                     tr_rd_addr    = prev_ff;
                     sr_rd_en      = 1'b1;
                     sr_rd_addr    = in_byte;
                     learn_en_in   = !in_new_text && prev_valid_ff;
                     learn_addr_in = {prev_ff, in_byte};
                     prev_in       = in_byte;
                     prev_valid_in = 1'b1;
                     state_in      = bcp_pkg::ST_LEARN;
                  end
                  bcp_pkg::CMD_PREDICT: begin
                     ctx_in    = in_byte;
                     remain_in = in_len;
                     if (in_len != 6'd0) begin
                        scan_cnt_in = '0;
                        best_in     = '0;
                        ties_in     = '0;
                        state_in    = bcp_pkg::ST_SCAN_MAX;
                     end
                  end
                  bcp_pkg::CMD_QUERY: begin
                     pr_rd_en   = 1'b1;
                     pr_rd_addr = {in_byte, in_succ};
                     tr_rd_en   = 1'b1;
                     tr_rd_addr = in_byte;
                     sr_rd_en   = 1'b1;
                     sr_rd_addr = in_byte;
                     ctx_in     = in_byte;
                     state_in   = bcp_pkg::ST_QUERY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         bcp_pkg::ST_LEARN: begin
            // increment pair count and row total if enabled and unsaturated; mark the byte seen
            pr_wr_en = pair_inc;
            tr_wr_en = pair_inc && (tr_rd_data != bcp_pkg::TOTAL_MAX);
            sr_wr_en = 1'b1;
            if (!sr_rd_data[0]) begin
               distinct_in = distinct_ff + 9'd1;
            end
            state_in = bcp_pkg::ST_IDLE;
         end
         bcp_pkg::ST_QUERY: begin
            if (out_free) begin
               out_valid_in    = 1'b1;
               out_kind_in     = bcp_pkg::KIND_QUERY;
               out_byte_in     = '0;
               out_count_in    = pr_rd_data;
               out_total_in    = tr_rd_data;
               out_seen_in     = sr_rd_data[0];
               out_distinct_in = distinct_ff;
               out_last_in     = 1'b1;
               state_in        = bcp_pkg::ST_IDLE;
            end
         end
         bcp_pkg::ST_SCAN_MAX: begin
            tr_rd_en = 1'b1;
            sr_rd_en = 1'b1;
            pr_rd_en = issuing;
            dv_in    = issuing;
            if (issuing) begin
               scan_cnt_in = scan_cnt_ff + 9'd1;
            end
            if (dv_ff) begin
               if (pr_rd_data > best_ff) begin
                  best_in = pr_rd_data;
                  ties_in = 9'd1;
               end else if (pr_rd_data == best_ff) begin
                  ties_in = ties_ff + 9'd1;
               end
            end
            if (scan_done) begin
               if (best_ff == 16'd0) begin
                  state_in = bcp_pkg::ST_STOP;
               end else begin
                  lfsr_in    = lfsr_step;
                  div_sh_in  = lfsr_step;
                  div_cnt_in = '0;
                  rem_in     = '0;
                  state_in   = bcp_pkg::ST_DIV;
               end
            end
         end
         bcp_pkg::ST_DIV: begin
            // restoring remainder, one bit of the LFSR value a cycle
            tr_rd_en   = 1'b1;
            sr_rd_en   = 1'b1;
            div_sh_in  = {div_sh_ff[14:0], 1'b0};
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_trial >= {1'b0, ties_ff}) begin
               rem_in = 9'(div_trial - {1'b0, ties_ff});
            end else begin
               rem_in = div_trial[8:0];
            end
            if (div_cnt_ff == 4'd15) begin
               scan_cnt_in = '0;
               match_in    = '0;
               state_in    = bcp_pkg::ST_SCAN_PICK;
            end
         end
         bcp_pkg::ST_SCAN_PICK: begin
            tr_rd_en = 1'b1;
            sr_rd_en = 1'b1;
            pr_rd_en = issuing;
            dv_in    = issuing;
            if (issuing) begin
               scan_cnt_in = scan_cnt_ff + 9'd1;
               col_in      = scan_cnt_ff[7:0];
            end
            if (dv_ff && pr_rd_data == best_ff) begin
               if (match_ff == rem_ff) begin
                  pick_in = col_ff;
               end
               match_in = match_ff + 9'd1;
            end
            if (scan_done) begin
               state_in = bcp_pkg::ST_EMIT;
            end
         end
         bcp_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in    = 1'b1;
               out_kind_in     = bcp_pkg::KIND_BYTE;
               out_byte_in     = pick_ff;
               out_count_in    = best_ff;
               out_total_in    = tr_rd_data;
               out_seen_in     = sr_rd_data[0];
               out_distinct_in = distinct_ff;
               out_last_in     = (remain_ff == 6'd1);
               ctx_in          = pick_ff;
               remain_in       = remain_ff - 6'd1;
               if (remain_ff == 6'd1) begin
                  state_in = bcp_pkg::ST_IDLE;
               end else begin
                  scan_cnt_in = '0;
                  best_in     = '0;
                  ties_in     = '0;
                  state_in    = bcp_pkg::ST_SCAN_MAX;
               end
            end
         end
         bcp_pkg::ST_STOP: begin
            if (out_free) begin
               out_valid_in    = 1'b1;
               out_kind_in     = bcp_pkg::KIND_STOP;
               out_byte_in     = ctx_ff;
               out_count_in    = '0;
               out_total_in    = tr_rd_data;
               out_seen_in     = sr_rd_data[0];
               out_distinct_in = distinct_ff;
               out_last_in     = 1'b1;
               state_in        = bcp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bcp_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         dv_ff         <= 1'b0;
         distinct_ff   <= '0;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         lfsr_ff       <= bcp_pkg::SEED_RESET;
         seed_ff       <= bcp_pkg::SEED_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         dv_ff         <= dv_in;
         distinct_ff   <= distinct_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         lfsr_ff       <= lfsr_in;
         seed_ff       <= seed_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff          <= ctx_in;
      remain_ff       <= remain_in;
      scan_cnt_ff     <= scan_cnt_in;
      col_ff          <= col_in;
      best_ff         <= best_in;
      ties_ff         <= ties_in;
      div_sh_ff       <= div_sh_in;
      div_cnt_ff      <= div_cnt_in;
      rem_ff          <= rem_in;
      match_ff        <= match_in;
      pick_ff         <= pick_in;
      learn_en_ff     <= learn_en_in;
      learn_addr_ff   <= learn_addr_in;
      out_kind_ff     <= out_kind_in;
      out_byte_ff     <= out_byte_in;
      out_count_ff    <= out_count_in;
      out_total_ff    <= out_total_in;
      out_seen_ff     <= out_seen_in;
      out_distinct_ff <= out_distinct_in;
      out_last_ff     <= out_last_in;
   end

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == bcp_pkg::ST_CLEAR |-> !rsp_tvalid)
      else $error("result shown during clearing pass");

   a_learn_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == bcp_pkg::ST_LEARN |-> $past(accept))
      else $error("learn write-back without an accepted request");

   a_div_ties: assert property (@(posedge clock) disable iff (reset)
      state_ff == bcp_pkg::ST_DIV |-> ties_ff != 9'd0)
      else $error("tie divider started with zero ties");

   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == bcp_pkg::ST_EMIT |-> match_ff > rem_ff)
      else $error("tie pick not found in second scan");

endmodule

// ===== sim/bigram_count_and_predict_checker.sv =====
// Checker for the bigram block: watches request, result and register traffic and compares results.
module bigram_count_and_predict_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_value, successor_byte, new_text, predict_length
   input  logic [1:0]  req_tuser,   // command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // out_byte, pair_count, successor_total, seen, distinct_count
   input  logic [1:0]  rsp_tuser,   // kind
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bcp_pkg::kind_type kind;
      bit [7:0]          out_byte;
      bit [15:0]         pair_count;
      bit [23:0]         total;
      bit                seen;
      bit [8:0]          distinct;
      bit                last;
   } bigram_result_type;

   bit [bcp_pkg::COUNT_BITS-1:0] pair_count_mem [bcp_pkg::PAIR_DEPTH];
   bit [bcp_pkg::TOTAL_BITS-1:0] total_mem [bcp_pkg::ROW_DEPTH];
   bit                           seen_mem [bcp_pkg::ROW_DEPTH];
   bit [8:0]                     distinct_seen;
   bit [7:0]                     prev_byte;
   bit                           prev_valid;
   bit [15:0]                    tie_lfsr;
   bigram_result_type            expected_results [$];

   task automatic push_result(bcp_pkg::kind_type k, bit [7:0] b, bit [15:0] cnt,
                              bit [7:0] pred, bit lst);
      bigram_result_type r;
      r.kind = k;
      r.out_byte = b;
      r.pair_count = cnt;
      r.total = total_mem[pred];
      r.seen = seen_mem[pred];
      r.distinct = distinct_seen;
      r.last = lst;
      expected_results.push_back(r);
   endtask

   task automatic learn_byte(bit [7:0] b, bit nt);
      bit [15:0] idx;
      if (!seen_mem[b]) begin
         seen_mem[b] = 1'b1;
         distinct_seen++;
      end
      if (!nt && prev_valid) begin
         idx = {prev_byte, b};
         if (pair_count_mem[idx] != bcp_pkg::COUNT_MAX) begin
            pair_count_mem[idx]++;
            if (total_mem[prev_byte] != bcp_pkg::TOTAL_MAX)
               total_mem[prev_byte]++;
         end
      end
      prev_byte = b;
      prev_valid = 1'b1;
   endtask

   task automatic predict_run(bit [7:0] context_byte, bit [5:0] run_len);
      bit [7:0]  ctx;
      bit [15:0] best, v;
      int        ties, choice, j, pick;
      ctx = context_byte;
      for (int i = 0; i < run_len; i++) begin
         best = 0;
         ties = 0;
         for (int c = 0; c < 256; c++) begin
            v = pair_count_mem[{ctx, c[7:0]}];
            if (v > best) begin
               best = v;
               ties = 1;
            end else if (v == best) begin
               ties++;
            end
         end
         if (best == 0) begin
            push_result(bcp_pkg::KIND_STOP, ctx, 16'd0, ctx, 1'b1);
            return;
         end
         // Galois step, then pick the tie at position lfsr mod ties in byte order
         tie_lfsr = tie_lfsr[0] ? ((tie_lfsr >> 1) ^ bcp_pkg::LFSR_MASK) : (tie_lfsr >> 1);
         choice = tie_lfsr % ties;
         j = 0;
         pick = 0;
         for (int c = 0; c < 256; c++) begin
            if (pair_count_mem[{ctx, c[7:0]}] == best) begin
               if (j == choice)
                  pick = c;
               j++;
            end
         end
         push_result(bcp_pkg::KIND_BYTE, pick[7:0], best, ctx, (i + 1 == run_len));
         ctx = pick[7:0];
      end
   endtask

   always @(posedge clock) begin
      bigram_result_type e;
      bit [7:0]          b, s;
      if (reset) begin
         foreach (pair_count_mem[i]) pair_count_mem[i] = '0;
         foreach (total_mem[i]) total_mem[i] = '0;
         foreach (seen_mem[i]) seen_mem[i] = 1'b0;
         distinct_seen = '0;
         prev_byte = '0;
         prev_valid = 1'b0;
         tie_lfsr = bcp_pkg::SEED_RESET;
         expected_results.delete();
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 3'd0)
            tie_lfsr = (csr_pwdata[15:0] == 16'd0) ? 16'd1 : csr_pwdata[15:0];
         if (req_tvalid && req_tready) begin
            b = req_tdata[7:0];
            s = req_tdata[15:8];
            case (req_tuser)
               bcp_pkg::CMD_LEARN:   learn_byte(b, req_tdata[16]);
               bcp_pkg::CMD_PREDICT: predict_run(b, req_tdata[22:17]);
               bcp_pkg::CMD_QUERY:
                  push_result(bcp_pkg::KIND_QUERY, 8'd0, pair_count_mem[{b, s}], b, 1'b1);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: kind %0d data %h last %0d",
                           rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               e = expected_results.pop_front();
               if (rsp_tuser != e.kind || rsp_tdata[7:0] != e.out_byte ||
                   rsp_tdata[23:8] != e.pair_count || rsp_tdata[47:24] != e.total ||
                   rsp_tdata[48] != e.seen || rsp_tdata[57:49] != e.distinct ||
                   rsp_tdata[63:58] != 6'd0 || rsp_tlast != e.last) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: expected kind %0d byte %h count %0d total %0d ",
                               "seen %0d distinct %0d last %0d; got kind %0d byte %h ",
                               "count %0d total %0d seen %0d distinct %0d last %0d"},
                              e.kind, e.out_byte, e.pair_count, e.total, e.seen,
                              e.distinct, e.last, rsp_tuser, rsp_tdata[7:0],
                              rsp_tdata[23:8], rsp_tdata[47:24], rsp_tdata[48],
                              rsp_tdata[57:49], rsp_tlast);
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== sim/tb_bigram_count_and_predict.sv =====
// Testbench top for the bigram block: clock, reset, stimulus and verdict.
module tb_bigram_count_and_predict;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   int          burst_left = 0;
   int          stall_left = 1;
   int          stall_mode = 0;

   always #5 clock = ~clock;

   bigram_count_and_predict u_top (.*);

   bigram_count_and_predict_checker u_checker (.*);

   // receiver: switch between always-ready, coin-flip and mostly-stalled stretches
   always @(negedge clock) begin
      if (--stall_left == 0) begin
         stall_mode = $urandom_range(2);
         stall_left = $urandom_range(5, 60);
      end
      case (stall_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = 1'($urandom_range(1));
         default: rsp_tready = ($urandom_range(7) == 0);
      endcase
   end

   task automatic send_request(bcp_pkg::cmd_type cmd, bit [7:0] b, bit [7:0] s, bit nt,
                               bit [5:0] len);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {1'b0, len, nt, s, b};
      do @(posedge clock); while (!req_tready);
      // after a random-length burst, usually drop valid for a gap
      if (--burst_left <= 0) begin
         burst_left = $urandom_range(1, 10);
         if ($urandom_range(3) != 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
   endtask

   task automatic drain_and_write_seed(bit [15:0] seed);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      // a trailing learn may still be busy
      repeat (40) @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = 3'd0;
      csr_pwdata = {16'd0, seed};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic bit [7:0] text_byte();
      return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h68));
   endfunction

   task automatic random_request();
      int        r;
      bit [5:0]  len;
      r = $urandom_range(99);
      if (r < 55) begin
         send_request(bcp_pkg::CMD_LEARN, text_byte(), 8'($urandom),
                      ($urandom_range(15) == 0), 6'($urandom));
      end else if (r < 75) begin
         r = $urandom_range(99);
         len = (r < 90) ? 6'($urandom_range(1, 4)) :
               (r < 97) ? 6'($urandom_range(5, 20)) : 6'($urandom_range(32, 63));
         send_request(bcp_pkg::CMD_PREDICT, text_byte(), 8'($urandom),
                      1'($urandom_range(1)), len);
      end else if (r < 97) begin
         send_request(bcp_pkg::CMD_QUERY, text_byte(), text_byte(), 1'($urandom_range(1)),
                      6'($urandom));
      end else begin
         send_request(bcp_pkg::cmd_type'(2'd3), 8'($urandom), 8'($urandom),
                      1'($urandom_range(1)), 6'($urandom));
      end
   endtask

   initial begin
      bit [15:0] seeds [4];
      seeds = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65534))};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes: first-text byte, all-zero and all-one bytes, repeated pair
      send_request(bcp_pkg::CMD_LEARN, 8'h00, 8'hFF, 1'b1, 6'h3F);
      send_request(bcp_pkg::CMD_LEARN, 8'hFF, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'h00, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'hFF, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_QUERY, 8'h00, 8'hFF, 1'b1, 6'h3F);
      send_request(bcp_pkg::CMD_QUERY, 8'hFF, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_QUERY, 8'h12, 8'h34, 1'b0, 6'h15);
      send_request(bcp_pkg::CMD_PREDICT, 8'h00, 8'h00, 1'b0, 6'd3);
      // no successor, empty run, unused command
      send_request(bcp_pkg::CMD_PREDICT, 8'h55, 8'hAA, 1'b1, 6'd5);
      send_request(bcp_pkg::CMD_PREDICT, 8'h00, 8'h00, 1'b0, 6'd0);
      send_request(bcp_pkg::cmd_type'(2'd3), 8'hA5, 8'h5A, 1'b1, 6'h2A);
      // three-way tie out of 'A', then the longest run
      send_request(bcp_pkg::CMD_LEARN, 8'h41, 8'h00, 1'b1, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'h42, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'h41, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'h43, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'h41, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'h44, 8'h00, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_LEARN, 8'h44, 8'h00, 1'b1, 6'h00);
      send_request(bcp_pkg::CMD_QUERY, 8'h44, 8'h44, 1'b0, 6'h00);
      send_request(bcp_pkg::CMD_PREDICT, 8'h41, 8'h00, 1'b0, 6'd63);
      send_request(bcp_pkg::CMD_PREDICT, 8'h44, 8'h00, 1'b0, 6'd2);

      foreach (seeds[p]) begin
         drain_and_write_seed(seeds[p]);
         repeat (60) random_request();
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1s;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/bcp_pkg.sv
rtl/core/bcp_ram.sv
rtl/core/bigram_count_and_predict.sv
sim/bigram_count_and_predict_checker.sv
sim/tb_bigram_count_and_predict.sv
